// ===== rtl/pls_pkg.sv =====
// Shared types, codes and constants of the parabolic line search block.
// Used by the shared multiplier, the shared divider and the top level.
`default_nettype none

package pls_pkg;

  // One request on the input channel.
  typedef struct packed {
    logic              operation;
    logic signed [31:0] start_point;
    logic signed [31:0] func_value;
  } in_req_t;

  // One request on the result channel.
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] point;
    logic signed [31:0] value;
  } out_req_t;

  // Input operations.
  localparam logic OP_START = 1'b0;
  localparam logic OP_VALUE = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_EVAL = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEEK_MIN   = 3'd4;

  // Reset values of the configuration registers.
  localparam logic signed [31:0] RANGE_LOW_RST  = 32'sh8000_0000;
  localparam logic signed [31:0] RANGE_HIGH_RST = 32'sh7FFF_FFFF;
  localparam logic [30:0]        BASE_STEP_RST  = 31'd65536;
  localparam logic [30:0]        TOLERANCE_RST  = 31'd66;

  // Fixed-point constants: one in Q16.16 and exact reciprocals for
  // 32-bit operands (x/10 = x*RECIP10 >> 35, x/3 = x*RECIP3 >> 33).
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
  localparam logic [31:0] RECIP3  = 32'hAAAA_AAAB;

  // Operand widths of the shared arithmetic units.
  localparam int MUL_A_W = 66;
  localparam int MUL_B_W = 33;
  localparam int DIV_N_W = 97;
  localparam int DIV_D_W = 66;
  localparam int DIV_Q_W = 42;

endpackage

`default_nettype wire

// ===== rtl/pls_mul.sv =====
// Shared shift-and-add multiplier, one multiplier bit per cycle.
// Its default widths come from pls_pkg; the top level sets them.
`default_nettype none

module pls_mul #(
  parameter int A_W = pls_pkg::MUL_A_W,
  parameter int B_W = pls_pkg::MUL_B_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               done,
  output logic [A_W+B_W-1:0] product
);

  localparam int P_W = A_W + B_W;

  logic           busy_r;
  logic           done_r;
  logic [P_W-1:0] a_r;
  logic [B_W-1:0] b_r;
  logic [P_W-1:0] acc_r;

  // Control: busy until the remaining multiplier bits are all zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
      end else if (busy_r && (b_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath: add the shifted multiplicand for each set multiplier bit.
  always_ff @(posedge clk) begin
    if (go) begin
      a_r   <= P_W'(a);
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r && (b_r != '0)) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

  assign done    = done_r;
  assign product = acc_r;

  // A new operation is only launched when the unit is free.
  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n) go |-> !busy_r)
    else $error("multiplier launched while busy");
  a_done_free: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("multiplier done while still busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done_r |=> !done_r)
    else $error("multiplier done lasted more than one cycle");

endmodule

`default_nettype wire

// ===== rtl/pls_div.sv =====
// Shared restoring divider, one quotient bit per cycle, clamping to the top bit
// when the quotient reaches it. Default widths come from pls_pkg, set at the top.
`default_nettype none

module pls_div #(
  parameter int N_W = pls_pkg::DIV_N_W,
  parameter int D_W = pls_pkg::DIV_D_W,
  parameter int Q_W = pls_pkg::DIV_Q_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           go,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic           done,
  output logic [Q_W-1:0] quot
);

  localparam int S_W = D_W + Q_W - 1;
  localparam int C_W = (S_W > N_W) ? S_W : N_W;
  localparam int I_W = (Q_W > 1) ? $clog2(Q_W) : 1;
  localparam logic [I_W-1:0] TOP_IDX = I_W'(Q_W - 1);

  logic           busy_r;
  logic           done_r;
  logic [N_W-1:0] rem_r;
  logic [S_W-1:0] dv_r;
  logic [Q_W-1:0] q_r;
  logic [I_W-1:0] idx_r;
  logic [C_W-1:0] rem_ext;
  logic [C_W-1:0] dv_ext;
  logic           ge;
  logic           last;

  assign rem_ext = C_W'(rem_r);
  assign dv_ext  = C_W'(dv_r);
  assign ge      = (rem_ext >= dv_ext);
  // A set top quotient bit clamps the quotient and ends the run; so does bit zero.
  assign last    = ((idx_r == TOP_IDX) && ge) || (idx_r == '0);

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath: compare, subtract and shift the divisor down one place.
  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= num;
      dv_r  <= S_W'(den) << (Q_W - 1);
      q_r   <= '0;
      idx_r <= TOP_IDX;
    end else if (busy_r) begin
      if (ge) begin
        rem_r      <= N_W'(rem_ext - dv_ext);
        q_r[idx_r] <= 1'b1;
      end
      if (!last) begin
        dv_r  <= dv_r >> 1;
        idx_r <= idx_r - 1'b1;
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n) go |-> !busy_r)
    else $error("divider launched while busy");
  a_done_free: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider done while still busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done_r |=> !done_r)
    else $error("divider done lasted more than one cycle");

endmodule

`default_nettype wire

// ===== rtl/parabolic_line_search.sv =====
// Parabolic line search sequencer. A start request (operation 0) gives the
// initial point; every result asks the outside evaluator for f at a point
// or ends the search with the point, its value and success or failure, and
// each value request (operation 1) returns f at the last asked point. All
// arithmetic is signed Q16.16. The block takes one request at a time and
// holds in_stall high while it works; a finished result waits in the output
// register without blocking the next request. Bracketing steps run through a
// shared shift-and-add multiplier (one product per step halving), and a
// vertex fit chains six products and a division. The user is to change the
// range, step, tolerance and direction registers only for the next request;
// the block itself does not enforce it.
`default_nettype none

module parabolic_line_search (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pls_pkg::in_req_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pls_pkg::out_req_t                   out_data,
  input  logic                                cfg_we,
  input  logic [pls_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                         cfg_data
);

  localparam int MA_W = pls_pkg::MUL_A_W;
  localparam int MB_W = pls_pkg::MUL_B_W;
  localparam int MP_W = MA_W + MB_W;

  typedef enum logic [3:0] {
    PH_IDLE, PH_FIRST, PH_PROBE, PH_REVERSE, PH_BRACKET, PH_ESCAPE,
    PH_VERTEX, PH_TRI_HIGH, PH_TRI_LOW
  } phase_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_MULW, S_DIVW, S_EMIT, S_GROWD, S_ADV, S_STEPD, S_HEAD,
    S_VPPD, S_VPPR, S_VQQ, S_VQQS, S_VPR, S_VQS, S_VDIV, S_VEND, S_VTRI,
    S_TRIH, S_TRIL
  } ctrl_t;

  // Configuration registers.
  logic signed [31:0] range_low_r, range_high_r;
  logic [30:0]        base_step_r, tolerance_r;
  logic               seek_min_r;

  // Search state.
  ctrl_t              state_r, ret_r, prev_state_r;
  phase_t             phase_r;
  logic signed [31:0] lp_r, lv_r, mp_r, mv_r, rp_r, rv_r;
  logic [31:0]        sf_r;
  logic [30:0]        hw_r;
  logic               dir_r;
  logic signed [97:0] num_r;
  logic signed [65:0] den_r;
  pls_pkg::in_req_t   req_r;
  pls_pkg::out_req_t  res_r, out_data_r;
  logic               out_valid_r;

  // Shared unit launch signals and operands.
  logic                         mul_go_w;
  logic [MA_W-1:0]              mul_a_r;
  logic [MB_W-1:0]              mul_b_r;
  logic                         div_go_w;
  logic [pls_pkg::DIV_N_W-1:0]  div_num_r;
  logic [pls_pkg::DIV_D_W-1:0]  div_den_r;
  logic                         mul_done_w, div_done_w;
  logic [MP_W-1:0]              prod_w;
  logic [pls_pkg::DIV_Q_W-1:0]  quot_w;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    if (x > 50'sh7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (x < -50'sh8000_0000) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

  // Values are stored negated when a maximum is sought.
  function automatic logic signed [31:0] orient(input logic signed [31:0] f,
                                                input logic seek);
    if (seek) begin
      return f;
    end else if (f == 32'sh8000_0000) begin
      return 32'sh7FFF_FFFF;
    end
    return -f;
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] a);
    return a[32] ? -a : a;
  endfunction

  // Shared units.
  pls_mul #(.A_W(MA_W), .B_W(MB_W)) u_mul (
    .clk(clk), .rst_n(rst_n), .go(mul_go_w), .a(mul_a_r), .b(mul_b_r),
    .done(mul_done_w), .product(prod_w)
  );

  pls_div #(
    .N_W(pls_pkg::DIV_N_W), .D_W(pls_pkg::DIV_D_W), .Q_W(pls_pkg::DIV_Q_W)
  ) u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go_w), .num(div_num_r), .den(div_den_r),
    .done(div_done_w), .quot(quot_w)
  );

  // Combinational helpers.
  logic signed [31:0] f_w;
  logic signed [32:0] pt_up_w, pt_dn_w;
  logic signed [32:0] p_w, q_w, r_w, s_w;
  logic [32:0]        pa_w, qa_w, ra_w, sa_w;
  logic [46:0]        off_w;
  logic signed [49:0] xu_w, xd_w, x_sel_w, x_opp_w;
  logic               x_out_w, dn_out_w;
  logic [32:0]        grow_w;
  logic [31:0]        w3_w;
  logic signed [97:0] pterm_w;
  logic signed [65:0] dterm_w;
  logic [97:0]        num_abs_w;
  logic [65:0]        den_abs_w;
  logic signed [42:0] voff_w;
  logic signed [43:0] vw_w;
  logic               v_in_w;
  logic [31:0]        wid_w;
  logic signed [33:0] rm_w, ml_w, tol34_w;
  logic               lt_w, swap_w;
  logic signed [31:0] nl_w, nr_w;

  assign f_w     = orient(req_r.func_value, seek_min_r);
  assign pt_up_w = 33'(mp_r) + $signed({2'b00, base_step_r});
  assign pt_dn_w = 33'(mp_r) - $signed({2'b00, base_step_r});
  assign dn_out_w = (50'(pt_dn_w) < range_low_r) || (50'(pt_dn_w) > range_high_r);

  assign p_w  = 33'(mp_r) - 33'(lp_r);
  assign q_w  = 33'(mp_r) - 33'(rp_r);
  assign r_w  = 33'(mv_r) - 33'(rv_r);
  assign s_w  = 33'(mv_r) - 33'(lv_r);
  assign pa_w = mag33(p_w);
  assign qa_w = mag33(q_w);
  assign ra_w = mag33(r_w);
  assign sa_w = mag33(s_w);

  // Bracketing step: offset is (base_step * step_factor) >> 16.
  assign off_w   = prod_w[62:16];
  assign xu_w    = 50'(mp_r) + $signed({3'b000, off_w});
  assign xd_w    = 50'(mp_r) - $signed({3'b000, off_w});
  assign x_sel_w = dir_r ? xu_w : xd_w;
  assign x_opp_w = dir_r ? xd_w : xu_w;
  assign x_out_w = (x_sel_w < range_low_r) || (x_sel_w > range_high_r);

  // Growth by 1.1 and trisection width.
  assign grow_w = {1'b0, sf_r} + {4'b0000, prod_w[63:35]};
  assign w3_w   = prod_w[64:33];

  // Vertex fit terms.
  assign pterm_w   = $signed({2'b00, prod_w[95:0]});
  assign dterm_w   = $signed({2'b00, prod_w[63:0]});
  assign num_abs_w = num_r[97] ? -num_r : num_r;
  assign den_abs_w = den_r[65] ? -den_r : den_r;
  assign voff_w    = (num_r[97] ^ den_r[65]) ? -$signed({1'b0, quot_w})
                                             : $signed({1'b0, quot_w});
  assign vw_w      = 44'(mp_r) - 44'(voff_w);
  assign v_in_w    = (vw_w < rp_r) && (vw_w > lp_r);

  // Bracket width and end distances.
  assign wid_w   = rp_r - lp_r;
  assign rm_w    = 34'(rp_r) - 34'(mp_r);
  assign ml_w    = 34'(mp_r) - 34'(lp_r);
  assign tol34_w = $signed({3'b000, tolerance_r});

  // Bracket close: order the end points.
  assign lt_w   = rv_r < mv_r;
  assign swap_w = rp_r < lp_r;
  assign nl_w   = swap_w ? rp_r : lp_r;
  assign nr_w   = swap_w ? lp_r : rp_r;

  // A shared unit starts in the first cycle of its wait state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_state_r <= S_IDLE;
    end else begin
      prev_state_r <= state_r;
    end
  end

  assign mul_go_w = (state_r == S_MULW) && (prev_state_r != S_MULW);
  assign div_go_w = (state_r == S_DIVW) && (prev_state_r != S_DIVW);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= pls_pkg::RANGE_LOW_RST;
      range_high_r <= pls_pkg::RANGE_HIGH_RST;
      base_step_r  <= pls_pkg::BASE_STEP_RST;
      tolerance_r  <= pls_pkg::TOLERANCE_RST;
      seek_min_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pls_pkg::CFG_RANGE_LOW:  range_low_r  <= cfg_data;
        pls_pkg::CFG_RANGE_HIGH: range_high_r <= cfg_data;
        pls_pkg::CFG_BASE_STEP:  base_step_r  <= cfg_data[30:0];
        pls_pkg::CFG_TOLERANCE:  tolerance_r  <= cfg_data[30:0];
        pls_pkg::CFG_SEEK_MIN:   seek_min_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
      lp_r <= '0; lv_r <= '0; mp_r <= '0; mv_r <= '0; rp_r <= '0; rv_r <= '0;
      sf_r  <= pls_pkg::ONE_Q16;
      hw_r  <= '0;
      dir_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r   <= in_data;
            state_r <= S_DISP;
          end
        end

        // Start a search on a start request; else act on the value by the search phase.
        S_DISP: begin
          if (req_r.operation == pls_pkg::OP_START) begin
            mp_r    <= req_r.start_point;
            sf_r    <= pls_pkg::ONE_Q16;
            res_r   <= '{kind: pls_pkg::KIND_EVAL, point: req_r.start_point, value: '0};
            phase_r <= PH_FIRST;
            state_r <= S_EMIT;
          end else begin
            unique case (phase_r)
              PH_FIRST: begin
                mv_r  <= f_w;
                lp_r  <= mp_r;
                lv_r  <= f_w;
                dir_r <= dn_out_w;
                rp_r  <= sat32(50'(dn_out_w ? pt_up_w : pt_dn_w));
                res_r <= '{kind: pls_pkg::KIND_EVAL,
                           point: sat32(50'(dn_out_w ? pt_up_w : pt_dn_w)), value: '0};
                phase_r <= PH_PROBE;
                state_r <= S_EMIT;
              end
              PH_PROBE: begin
                rv_r <= f_w;
                if (f_w >= mv_r) begin
                  lp_r  <= rp_r;
                  lv_r  <= f_w;
                  dir_r <= !dir_r;
                  rp_r  <= sat32(50'(dir_r ? pt_dn_w : pt_up_w));
                  res_r <= '{kind: pls_pkg::KIND_EVAL,
                             point: sat32(50'(dir_r ? pt_dn_w : pt_up_w)), value: '0};
                  phase_r <= PH_REVERSE;
                  state_r <= S_EMIT;
                end else begin
                  sf_r    <= pls_pkg::ONE_Q16;
                  state_r <= S_ADV;
                end
              end
              PH_REVERSE: begin
                rv_r    <= f_w;
                sf_r    <= pls_pkg::ONE_Q16;
                state_r <= S_ADV;
              end
              PH_BRACKET: begin
                rv_r     <= f_w;
                mul_a_r  <= {34'd0, sf_r};
                mul_b_r  <= {1'b0, pls_pkg::RECIP10};
                ret_r    <= S_GROWD;
                state_r  <= S_MULW;
              end
              PH_ESCAPE: begin
                rv_r    <= f_w;
                res_r   <= '{kind: pls_pkg::KIND_FAIL, point: rp_r,
                             value: orient(f_w, seek_min_r)};
                phase_r <= PH_IDLE;
                state_r <= S_EMIT;
              end
              PH_VERTEX: begin
                // The probed vertex point is held in the step factor.
                if (f_w < mv_r) begin
                  if ($signed(sf_r) > mp_r) begin
                    lp_r <= mp_r;
                    lv_r <= mv_r;
                  end else begin
                    rp_r <= mp_r;
                    rv_r <= mv_r;
                  end
                  mp_r <= sf_r;
                  mv_r <= f_w;
                end else if ($signed(sf_r) > mp_r) begin
                  rp_r <= sf_r;
                  rv_r <= f_w;
                end else begin
                  lp_r <= sf_r;
                  lv_r <= f_w;
                end
                state_r <= S_VTRI;
              end
              PH_TRI_HIGH: begin
                mv_r <= f_w;
                hw_r <= wid_w[31:1];
                if ((f_w > rv_r) && (wid_w[31:1] > tolerance_r)) begin
                  lp_r     <= mp_r;
                  lv_r     <= f_w;
                  mul_a_r  <= {34'd0, 32'(rp_r - mp_r)};
                  mul_b_r  <= {1'b0, pls_pkg::RECIP3};
                  ret_r    <= S_TRIH;
                  state_r  <= S_MULW;
                end else begin
                  state_r <= S_HEAD;
                end
              end
              PH_TRI_LOW: begin
                mv_r <= f_w;
                hw_r <= wid_w[31:1];
                if ((f_w > lv_r) && (wid_w[31:1] > tolerance_r)) begin
                  rp_r     <= mp_r;
                  rv_r     <= f_w;
                  mul_a_r  <= {34'd0, 32'(mp_r - lp_r)};
                  mul_b_r  <= {1'b0, pls_pkg::RECIP3};
                  ret_r    <= S_TRIL;
                  state_r  <= S_MULW;
                end else begin
                  state_r <= S_HEAD;
                end
              end
              default: begin
                // A value with no search running is dropped.
                phase_r <= PH_IDLE;
                state_r <= S_IDLE;
              end
            endcase
          end
        end

        S_MULW: begin
          if (mul_done_w) begin
            state_r <= ret_r;
          end
        end

        S_DIVW: begin
          if (div_done_w) begin
            state_r <= S_VEND;
          end
        end

        // Step factor grows by a tenth, saturating at all ones.
        S_GROWD: begin
          sf_r    <= grow_w[32] ? 32'hFFFF_FFFF : grow_w[31:0];
          state_r <= S_ADV;
        end

        // Keep stepping while the new point is lower, else close the bracket.
        S_ADV: begin
          if (lt_w) begin
            lp_r     <= mp_r;
            lv_r     <= mv_r;
            mp_r     <= rp_r;
            mv_r     <= rv_r;
            mul_a_r  <= {35'd0, base_step_r};
            mul_b_r  <= {1'b0, sf_r};
            ret_r    <= S_STEPD;
            state_r  <= S_MULW;
          end else begin
            lp_r    <= nl_w;
            rp_r    <= nr_w;
            lv_r    <= swap_w ? rv_r : lv_r;
            rv_r    <= swap_w ? lv_r : rv_r;
            hw_r    <= 31'((32'(nr_w - nl_w)) >> 1);
            state_r <= S_HEAD;
          end
        end

        // Halve the step while it leaves the range; escape backward if stuck.
        S_STEPD: begin
          if (x_out_w && (sf_r > 32'(tolerance_r))) begin
            sf_r     <= sf_r >> 1;
            mul_a_r  <= {35'd0, base_step_r};
            mul_b_r  <= {2'b00, sf_r[31:1]};
            ret_r    <= S_STEPD;
            state_r  <= S_MULW;
          end else if (x_out_w) begin
            rp_r    <= sat32(x_opp_w);
            res_r   <= '{kind: pls_pkg::KIND_EVAL, point: sat32(x_opp_w), value: '0};
            phase_r <= PH_ESCAPE;
            state_r <= S_EMIT;
          end else begin
            rp_r    <= x_sel_w[31:0];
            res_r   <= '{kind: pls_pkg::KIND_EVAL, point: x_sel_w[31:0], value: '0};
            phase_r <= PH_BRACKET;
            state_r <= S_EMIT;
          end
        end

        // Refine with a vertex fit while the bracket is wide enough, else finish.
        S_HEAD: begin
          if (hw_r > tolerance_r) begin
            mul_a_r  <= {33'd0, pa_w};
            mul_b_r  <= pa_w;
            ret_r    <= S_VPPD;
            state_r  <= S_MULW;
          end else begin
            res_r   <= '{kind: pls_pkg::KIND_DONE, point: mp_r,
                         value: orient(mv_r, seek_min_r)};
            phase_r <= PH_IDLE;
            state_r <= S_EMIT;
          end
        end

        // Numerator p*p*r - q*q*s and denominator p*r - q*s, built one product at a time.
        S_VPPD: begin
          mul_a_r  <= prod_w[MA_W-1:0];
          mul_b_r  <= ra_w;
          ret_r    <= S_VPPR;
          state_r  <= S_MULW;
        end
        S_VPPR: begin
          num_r    <= r_w[32] ? -pterm_w : pterm_w;
          mul_a_r  <= {33'd0, qa_w};
          mul_b_r  <= qa_w;
          ret_r    <= S_VQQ;
          state_r  <= S_MULW;
        end
        S_VQQ: begin
          mul_a_r  <= prod_w[MA_W-1:0];
          mul_b_r  <= sa_w;
          ret_r    <= S_VQQS;
          state_r  <= S_MULW;
        end
        S_VQQS: begin
          num_r    <= num_r - (s_w[32] ? -pterm_w : pterm_w);
          mul_a_r  <= {33'd0, pa_w};
          mul_b_r  <= ra_w;
          ret_r    <= S_VPR;
          state_r  <= S_MULW;
        end
        S_VPR: begin
          den_r    <= (p_w[32] ^ r_w[32]) ? -dterm_w : dterm_w;
          mul_a_r  <= {33'd0, qa_w};
          mul_b_r  <= sa_w;
          ret_r    <= S_VQS;
          state_r  <= S_MULW;
        end
        S_VQS: begin
          den_r   <= den_r - ((q_w[32] ^ s_w[32]) ? -dterm_w : dterm_w);
          state_r <= S_VDIV;
        end

        // A flat parabola counts as a vertex outside the bracket.
        S_VDIV: begin
          if (den_r == '0) begin
            res_r   <= '{kind: pls_pkg::KIND_FAIL, point: mp_r,
                         value: orient(mv_r, seek_min_r)};
            phase_r <= PH_IDLE;
            state_r <= S_EMIT;
          end else begin
            div_num_r <= num_abs_w[pls_pkg::DIV_N_W-1:0];
            div_den_r <= {den_abs_w[64:0], 1'b0};
            state_r   <= S_DIVW;
          end
        end

        S_VEND: begin
          if (v_in_w) begin
            sf_r    <= vw_w[31:0];
            res_r   <= '{kind: pls_pkg::KIND_EVAL, point: vw_w[31:0], value: '0};
            phase_r <= PH_VERTEX;
          end else begin
            res_r   <= '{kind: pls_pkg::KIND_FAIL, point: mp_r,
                         value: orient(mv_r, seek_min_r)};
            phase_r <= PH_IDLE;
          end
          state_r <= S_EMIT;
        end

        // Fall back to trisection when the middle hugs an end.
        S_VTRI: begin
          hw_r <= wid_w[31:1];
          if ((rm_w < tol34_w) && (wid_w[31:1] > tolerance_r)) begin
            rp_r     <= mp_r;
            rv_r     <= mv_r;
            mul_a_r  <= {34'd0, 32'(mp_r - lp_r)};
            mul_b_r  <= {1'b0, pls_pkg::RECIP3};
            ret_r    <= S_TRIH;
            state_r  <= S_MULW;
          end else if ((ml_w < tol34_w) && (wid_w[31:1] > tolerance_r)) begin
            lp_r     <= mp_r;
            lv_r     <= mv_r;
            mul_a_r  <= {34'd0, 32'(rp_r - mp_r)};
            mul_b_r  <= {1'b0, pls_pkg::RECIP3};
            ret_r    <= S_TRIL;
            state_r  <= S_MULW;
          end else begin
            state_r <= S_HEAD;
          end
        end

        S_TRIH: begin
          mp_r    <= rp_r - w3_w;
          res_r   <= '{kind: pls_pkg::KIND_EVAL, point: rp_r - w3_w, value: '0};
          phase_r <= PH_TRI_HIGH;
          state_r <= S_EMIT;
        end

        S_TRIL: begin
          mp_r    <= lp_r + w3_w;
          res_r   <= '{kind: pls_pkg::KIND_EVAL, point: lp_r + w3_w, value: '0};
          phase_r <= PH_TRI_LOW;
          state_r <= S_EMIT;
        end

        // Hand the result to the output register once it is free.
        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A shared unit only finishes while the sequencer waits for it.
  a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
      mul_done_w |-> (state_r == S_MULW))
    else $error("multiplier result arrived outside its wait state");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
      div_done_w |-> (state_r == S_DIVW))
    else $error("divider result arrived outside its wait state");
  // Ending results close the search; evaluate requests keep it running.
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
      ((state_r == S_EMIT) && (res_r.kind != pls_pkg::KIND_EVAL)) |-> (phase_r == PH_IDLE))
    else $error("search still running after an ending result");
  a_eval_run: assert property (@(posedge clk) disable iff (!rst_n)
      ((state_r == S_EMIT) && (res_r.kind == pls_pkg::KIND_EVAL)) |-> (phase_r != PH_IDLE))
    else $error("evaluate request issued with no search running");

endmodule

`default_nettype wire
